>>> hdl/mtd_pkg.sv
package mtd_pkg;

  localparam int unsigned TimeWidth        = 16;
  localparam int unsigned ByteWidth        = 8;
  localparam int unsigned CfgDataWidth     = 16;
  localparam int unsigned CfgAddrWidth     = 2;
  localparam int unsigned BitsPerWordDflt  = 8;

  localparam logic [CfgDataWidth-1:0] HalfLowRst  = 16'd49;
  localparam logic [CfgDataWidth-1:0] HalfHighRst = 16'd145;
  localparam logic [CfgDataWidth-1:0] FullLowRst  = 16'd146;
  localparam logic [CfgDataWidth-1:0] FullHighRst = 16'd242;

  typedef enum logic [1:0] {
    KIND_WORD     = 2'd0,
    KIND_LOST_T   = 2'd1,
    KIND_LOST_MID = 2'd2
  } kind_t;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_HALF_LOW  = 2'd0,
    REG_HALF_HIGH = 2'd1,
    REG_FULL_LOW  = 2'd2,
    REG_FULL_HIGH = 2'd3
  } reg_idx_t;

endpackage

>>> hdl/manchester_edge_timing_decoder_core.sv
// Channel  | Ports           | Contents (lowest bit first)
// in_      | tvalid/tready   | tdata: capture_time[15:0]
// out_     | tvalid/tready   | tdata: data_byte[7:0], bad_interval[15:0]; tuser: kind[1:0]
// cfg_     | we/addr/wdata   | 0 half_low, 1 half_high, 2 full_low, 3 full_high
//
// One edge transaction per cycle sustained while no result is stalled; out_tvalid
// rises for an edge that completes a word or loses sync, via the input register,
// then the interval compare and state update into the result register.
// Reset (rst_n low, synchronous) clears decoder state and reloads the thresholds.
// A stalled result holds the edge in the input register; in_tready drops only
// while both registers are full and out_tready is low.
module manchester_edge_timing_decoder_core #(
  parameter int unsigned BITS_PER_WORD = mtd_pkg::BitsPerWordDflt
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [15:0]                           in_tdata,   // capture_time[15:0]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [23:0]                           out_tdata,  // data_byte[7:0], bad_interval[23:8]
  output logic [1:0]                            out_tuser,  // kind[1:0]
  input  logic                                  cfg_we,
  input  logic [mtd_pkg::CfgAddrWidth-1:0]      cfg_addr,
  input  logic [mtd_pkg::CfgDataWidth-1:0]      cfg_wdata
);
  import mtd_pkg::*;

  localparam int unsigned CntWidth = $clog2(BITS_PER_WORD + 1);
  localparam int unsigned ExtWidth = (BITS_PER_WORD > ByteWidth) ? BITS_PER_WORD : ByteWidth;

  logic [CfgDataWidth-1:0]  half_low_r, half_high_r, full_low_r, full_high_r;

  logic                     in_valid_r;
  logic [TimeWidth-1:0]     cap_r;

  logic                     locked_r, locked_nxt;
  logic                     mid_r, mid_nxt;
  logic [BITS_PER_WORD-1:0] shift_r, shift_nxt;
  logic [CntWidth-1:0]      count_r, count_nxt;
  logic                     pol_r, pol_nxt;
  logic [TimeWidth-1:0]     last_edge_r, last_edge_nxt;

  logic                     out_valid_r;
  kind_t                    kind_r;
  logic [ByteWidth-1:0]     byte_r;
  logic [TimeWidth-1:0]     bad_r;

  logic                     advance, proc, glitch, in_full, in_half;
  logic                     emit, lost;
  kind_t                    res_kind;
  logic [TimeWidth-1:0]     iv;
  logic [ExtWidth-1:0]      shift_ext;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign proc      = in_valid_r && advance;

  assign iv      = cap_r - last_edge_r;
  assign glitch  = iv <= half_low_r;
  assign in_full = (iv > full_low_r) && (iv < full_high_r);
  assign in_half = (iv > half_low_r) && (iv < half_high_r);

  always_comb begin
    locked_nxt    = locked_r;
    mid_nxt       = mid_r;
    shift_nxt     = shift_r;
    count_nxt     = count_r;
    pol_nxt       = pol_r;
    last_edge_nxt = last_edge_r;
    lost          = 1'b0;
    res_kind      = KIND_WORD;
    if (proc && !glitch) begin
      last_edge_nxt = cap_r;
      pol_nxt       = !pol_r;
      if (!locked_r) begin
        if (in_full) begin
          shift_nxt  = BITS_PER_WORD'(pol_r);
          count_nxt  = CntWidth'(1);
          mid_nxt    = 1'b1;
          locked_nxt = 1'b1;
        end
      end else if (mid_r) begin
        priority if (in_full) begin
          shift_nxt = (shift_r << 1) | BITS_PER_WORD'(pol_r);
          count_nxt = count_r + CntWidth'(1);
        end else if (in_half) begin
          mid_nxt = 1'b0;
        end else begin
          lost     = 1'b1;
          res_kind = KIND_LOST_MID;
        end
      end else begin
        if (in_half) begin
          shift_nxt = (shift_r << 1) | BITS_PER_WORD'(pol_r);
          count_nxt = count_r + CntWidth'(1);
          mid_nxt   = 1'b1;
        end else begin
          lost     = 1'b1;
          res_kind = KIND_LOST_T;
        end
      end
      if (lost) begin
        locked_nxt = 1'b0;
      end
    end
  end

  assign shift_ext = ExtWidth'(shift_nxt);
  assign emit = proc && !glitch &&
                (lost || (locked_nxt && count_nxt == CntWidth'(BITS_PER_WORD)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_low_r  <= HalfLowRst;
      half_high_r <= HalfHighRst;
      full_low_r  <= FullLowRst;
      full_high_r <= FullHighRst;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_HALF_LOW:  half_low_r  <= cfg_wdata;
        REG_HALF_HIGH: half_high_r <= cfg_wdata;
        REG_FULL_LOW:  full_low_r  <= cfg_wdata;
        REG_FULL_HIGH: full_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      locked_r    <= 1'b0;
      mid_r       <= 1'b0;
      shift_r     <= '0;
      count_r     <= '0;
      pol_r       <= 1'b0;
      last_edge_r <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= emit;
      end
      locked_r    <= locked_nxt;
      mid_r       <= mid_nxt;
      pol_r       <= pol_nxt;
      last_edge_r <= last_edge_nxt;
      if (emit && !lost) begin
        shift_r <= '0;
        count_r <= '0;
      end else begin
        shift_r <= shift_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cap_r <= in_tdata;
    end
    if (emit) begin
      kind_r <= res_kind;
      byte_r <= shift_ext[ByteWidth-1:0];
      bad_r  <= lost ? iv : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bad_r, byte_r};
  assign out_tuser  = kind_r;

  a_word_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_WORD |-> bad_r == '0)
    else $error("word result carries a nonzero interval");

  a_loss_unlocks: assert property (@(posedge clk) disable iff (!rst_n)
    emit && lost |=> !locked_r)
    else $error("decoder still locked after loss of sync");

  a_glitch_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
    proc && glitch |=> $stable(last_edge_r) && $stable(pol_r))
    else $error("glitch changed edge time or polarity");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CntWidth'(BITS_PER_WORD) || !locked_r)
    else $error("bit count reached a full word while locked");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule
